FILE: rtl/core/brrw_pkg.sv
// brrw_pkg: shared types and constants of the banked rom/ram window controller
// no dependencies; used by brrw_regs, brrw_mem and the top level

package brrw_pkg;

  // bus operation codes
  typedef enum logic [2:0] {
    OP_REG_RD   = 3'd0,
    OP_REG_WR   = 3'd1,
    OP_WIN_RD   = 3'd2,
    OP_WIN_WR   = 3'd3,
    OP_ROM_LOAD = 3'd4
  } op_e;

  // i/o register addresses
  localparam logic [15:0] ADDR_PORTB_DIR  = 16'h0320;
  localparam logic [15:0] ADDR_PORTA_DIR  = 16'h0321;
  localparam logic [15:0] ADDR_PORTB_DATA = 16'h0322;
  localparam logic [15:0] ADDR_PORTA_DATA = 16'h0323;
  localparam logic [15:0] ADDR_CONTROL    = 16'h0342;
  localparam logic [15:0] ADDR_EXTENSION  = 16'h0343;

  // register reset values
  localparam logic [7:0] CONTROL_RST   = 8'd129;
  localparam logic [7:0] EXTENSION_RST = 8'd0;
  localparam logic [7:0] PORTA_RST     = 8'd7;
  localparam logic [7:0] PORTB_RST     = 8'd0;
  localparam logic [2:0] SEL_BANK_RST  = 3'd7;

  // bank mapping constants
  localparam int SEL_W          = 3;
  localparam int CTRL_RAM_BIT   = 5;
  localparam int EXT_BASE_OFS   = 8;
  localparam int EXT_STEP       = 4;
  localparam int EXT_LAST_BANK  = 4;
  localparam int EXT_ENTRIES    = 256;
  localparam int LOAD_BANK_W    = 5;
  localparam int WIN_ADDR_W     = 14;

  // memory access request flags, at most one set per cycle
  typedef struct packed {
    logic ram_rd;
    logic rom_rd;
    logic ram_wr;
    logic rom_wr;
  } mem_req_t;

endpackage

FILE: rtl/core/banked_rom_ram_window_controller.sv
// banked_rom_ram_window_controller: top level, request decode, read stage and output register
// depends on brrw_pkg, brrw_regs, brrw_mem
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+---------------------------------------
//  request  | in        | in_valid_i / in_stall_o  | operation_i address_i write_data_i
//           |           |                          | load_bank_i
//  result   | out       | out_valid_o / out_stall_i| read_data_o
//
// one request per cycle while the result side drains; each request gives one result,
// which passes through the read stage (memory read register) and then the output register
// after reset, bank 0 of ram is zeroed by a clearing pass; no request is taken during it
// a stalled result parks in the output register, the next result waits in the read
// stage, and outside the clearing pass requests are held off only when both are full

module banked_rom_ram_window_controller #(
  parameter int BANK_COUNT = 32,
  parameter int BANK_BYTES = 16384
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  input  logic [4:0]  load_bank_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_data_o
);

  localparam int BW = $clog2(BANK_COUNT);

  brrw_pkg::op_e      op;
  brrw_pkg::mem_req_t mem_req;
  logic               accept;
  logic               reg_wr;
  logic [7:0]         reg_rdata;
  logic [BW-1:0]      phys_bank;
  logic               win_ram;
  logic [7:0]         mem_rdata;
  logic               clearing;
  logic               move;

  // read stage: one request whose result is not yet in the output register
  logic               pend_q;
  logic               pend_mem_q;
  logic [7:0]         pend_val_q;
  // output register
  logic               out_valid_q;
  logic [7:0]         out_data_q;

  assign op     = brrw_pkg::op_e'(operation_i);
  assign move   = pend_q && (!out_valid_q || !out_stall_i);
  assign accept = in_valid_i && !in_stall_o;

  // no forwarding needed: a request does one memory access, and a read after a
  // write to the same entry comes at a later edge than the write
  always_comb begin
    mem_req = '0;
    reg_wr  = 1'b0;
    if (accept) begin
      unique case (op)
        brrw_pkg::OP_REG_WR:   reg_wr         = 1'b1;
        brrw_pkg::OP_WIN_RD: begin
          mem_req.ram_rd = win_ram;
          mem_req.rom_rd = !win_ram;
        end
        brrw_pkg::OP_WIN_WR:   mem_req.ram_wr = win_ram;   // writes to rom are dropped
        brrw_pkg::OP_ROM_LOAD: mem_req.rom_wr = 1'b1;
        default: ;
      endcase
    end
  end

  brrw_regs #(
    .BANK_COUNT (BANK_COUNT)
  ) u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (reg_wr),
    .addr_i      (address_i),
    .wdata_i     (write_data_i),
    .rdata_o     (reg_rdata),
    .phys_bank_o (phys_bank),
    .win_ram_o   (win_ram)
  );

  brrw_mem #(
    .BANK_COUNT (BANK_COUNT),
    .BANK_BYTES (BANK_BYTES)
  ) u_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (mem_req),
    .win_bank_i  (phys_bank),
    .load_bank_i (load_bank_i),
    .offset_i    (address_i[brrw_pkg::WIN_ADDR_W-1:0]),
    .wdata_i     (write_data_i),
    .rdata_o     (mem_rdata),
    .clearing_o  (clearing)
  );

  // memory read data holds until the next read, so the read stage can wait
  assign in_stall_o = clearing || (pend_q && !move);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        pend_q <= 1'b1;
      end else if (move) begin
        pend_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_mem_q <= (op == brrw_pkg::OP_WIN_RD);
      pend_val_q <= (op == brrw_pkg::OP_REG_RD) ? reg_rdata : 8'd0;
    end
    if (move) begin
      out_data_q <= pend_mem_q ? mem_rdata : pend_val_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;

`ifndef SYNTHESIS
  a_no_req_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !accept)
    else $error("request taken during the clearing pass");

  a_mem_req_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({mem_req.ram_rd, mem_req.rom_rd, mem_req.ram_wr, mem_req.rom_wr}))
    else $error("more than one memory access in a cycle");

  a_pend_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && out_valid_q && out_stall_i) |=> pend_q)
    else $error("read stage lost a result while the output was stalled");

  a_out_from_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(pend_q))
    else $error("result shown without a request in the read stage");
`endif

endmodule

FILE: rtl/core/brrw_regs.sv
// brrw_regs: the six i/o byte registers, the selected bank and the registered bank mapping
// depends on brrw_pkg

module brrw_regs #(
  parameter int BANK_COUNT = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [15:0]                   addr_i,
  input  logic [7:0]                    wdata_i,
  output logic [7:0]                    rdata_o,
  output logic [$clog2(BANK_COUNT)-1:0] phys_bank_o,
  output logic                          win_ram_o
);

  localparam int BW = $clog2(BANK_COUNT);

  logic [7:0]                   control_q, control_d;
  logic [7:0]                   extension_q, extension_d;
  logic [7:0]                   porta_data_q, porta_data_d;
  logic [7:0]                   porta_dir_q, porta_dir_d;
  logic [7:0]                   portb_data_q, portb_data_d;
  logic [7:0]                   portb_dir_q, portb_dir_d;
  logic [brrw_pkg::SEL_W-1:0]   sel_q, sel_d;
  logic [BW-1:0]                phys_q, phys_d;
  logic                         win_ram_q, win_ram_d;
  logic [BW:0]                  ext_sum;
  logic [BW-1:0]                ext_base [brrw_pkg::EXT_ENTRIES];

  // relocated base of extension banks, one entry per extension value
  for (genvar g = 0; g < brrw_pkg::EXT_ENTRIES; g++) begin : g_ext_base
    if (g == 0) begin : g_zero
      assign ext_base[g] = '0;
    end else begin : g_rel
      assign ext_base[g] = BW'((brrw_pkg::EXT_BASE_OFS + (g - 1) * brrw_pkg::EXT_STEP)
                               % BANK_COUNT);
    end
  end

  always_comb begin
    control_d    = control_q;
    extension_d  = extension_q;
    porta_data_d = porta_data_q;
    porta_dir_d  = porta_dir_q;
    portb_data_d = portb_data_q;
    portb_dir_d  = portb_dir_q;
    sel_d        = sel_q;
    if (wr_en_i) begin
      unique case (addr_i)
        brrw_pkg::ADDR_PORTA_DATA: porta_data_d = wdata_i;
        brrw_pkg::ADDR_PORTA_DIR: begin
          porta_dir_d = wdata_i;
          sel_d       = wdata_i[brrw_pkg::SEL_W-1:0];
        end
        brrw_pkg::ADDR_PORTB_DATA: portb_data_d = wdata_i;
        brrw_pkg::ADDR_PORTB_DIR:  portb_dir_d  = wdata_i;
        brrw_pkg::ADDR_CONTROL:    control_d    = wdata_i;
        brrw_pkg::ADDR_EXTENSION:  extension_d  = wdata_i;
        default: ;
      endcase
    end
  end

  // mapping from next-state values, so it is current for the next request
  always_comb begin
    ext_sum = {1'b0, ext_base[extension_d]} + (BW+1)'(sel_d);
    if (ext_sum >= (BW+1)'(BANK_COUNT)) begin
      ext_sum = ext_sum - (BW+1)'(BANK_COUNT);
    end
    if (sel_d != '0 && sel_d <= brrw_pkg::SEL_W'(brrw_pkg::EXT_LAST_BANK) &&
        extension_d != '0) begin
      phys_d = ext_sum[BW-1:0];
    end else begin
      phys_d = BW'(sel_d);
    end
    win_ram_d = (sel_d == '0) ||
                (sel_d <= brrw_pkg::SEL_W'(brrw_pkg::EXT_LAST_BANK) &&
                 control_d[brrw_pkg::CTRL_RAM_BIT]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      control_q    <= brrw_pkg::CONTROL_RST;
      extension_q  <= brrw_pkg::EXTENSION_RST;
      porta_data_q <= brrw_pkg::PORTA_RST;
      porta_dir_q  <= brrw_pkg::PORTA_RST;
      portb_data_q <= brrw_pkg::PORTB_RST;
      portb_dir_q  <= brrw_pkg::PORTB_RST;
      sel_q        <= brrw_pkg::SEL_BANK_RST;
      phys_q       <= BW'(brrw_pkg::SEL_BANK_RST);
      win_ram_q    <= 1'b0;
    end else begin
      control_q    <= control_d;
      extension_q  <= extension_d;
      porta_data_q <= porta_data_d;
      porta_dir_q  <= porta_dir_d;
      portb_data_q <= portb_data_d;
      portb_dir_q  <= portb_dir_d;
      sel_q        <= sel_d;
      phys_q       <= phys_d;
      win_ram_q    <= win_ram_d;
    end
  end

  always_comb begin
    unique case (addr_i)
      brrw_pkg::ADDR_CONTROL:    rdata_o = control_q;
      brrw_pkg::ADDR_PORTA_DATA: rdata_o = porta_data_q;
      brrw_pkg::ADDR_PORTA_DIR:  rdata_o = porta_dir_q;
      brrw_pkg::ADDR_PORTB_DATA: rdata_o = portb_data_q;
      brrw_pkg::ADDR_PORTB_DIR:  rdata_o = portb_dir_q;
      brrw_pkg::ADDR_EXTENSION:  rdata_o = extension_q;
      default:                   rdata_o = '0;
    endcase
  end

  assign phys_bank_o = phys_q;
  assign win_ram_o   = win_ram_q;

endmodule

FILE: rtl/core/brrw_mem.sv
// brrw_mem: ram and rom arrays, address formation and the bank 0 clearing pass
// depends on brrw_pkg

module brrw_mem #(
  parameter int BANK_COUNT = 32,
  parameter int BANK_BYTES = 16384
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  brrw_pkg::mem_req_t                  req_i,
  input  logic [$clog2(BANK_COUNT)-1:0]       win_bank_i,
  input  logic [brrw_pkg::LOAD_BANK_W-1:0]    load_bank_i,
  input  logic [brrw_pkg::WIN_ADDR_W-1:0]     offset_i,
  input  logic [7:0]                          wdata_i,
  output logic [7:0]                          rdata_o,
  output logic                                clearing_o
);

  localparam int BW    = $clog2(BANK_COUNT);
  localparam int OW    = $clog2(BANK_BYTES);
  localparam int AW    = $clog2(BANK_COUNT * BANK_BYTES);
  localparam int DEPTH = BANK_COUNT * BANK_BYTES;
  localparam int LB_N  = 1 << brrw_pkg::LOAD_BANK_W;
  localparam int QW    = 5;
  localparam int CW    = brrw_pkg::WIN_ADDR_W + QW;

  logic [7:0]    ram_mem [DEPTH];
  logic [7:0]    rom_mem [DEPTH];
  logic [7:0]    ram_rd_q, rom_rd_q;
  logic          rd_ram_q;
  logic          clr_q;
  logic [OW-1:0] clr_cnt_q;
  logic [BW-1:0] lb_mod [LB_N];
  logic [BW-1:0] bank;
  logic [QW-1:0] quot;
  logic [brrw_pkg::WIN_ADDR_W-1:0] off_full;
  logic [OW-1:0] off;
  logic [AW-1:0] idx;

  for (genvar g = 0; g < LB_N; g++) begin : g_lb_mod
    assign lb_mod[g] = BW'(g % BANK_COUNT);
  end

  // offset modulo bank size: the quotient is small, found by parallel compares
  always_comb begin
    quot = '0;
    for (int k = 1; k < (1 << brrw_pkg::WIN_ADDR_W) / 1024; k++) begin
      if (CW'(offset_i) >= CW'(k * BANK_BYTES)) begin
        quot = quot + QW'(1);
      end
    end
    off_full = offset_i - brrw_pkg::WIN_ADDR_W'(32'(quot) * BANK_BYTES);
    off      = off_full[OW-1:0];
    bank     = req_i.rom_wr ? lb_mod[load_bank_i] : win_bank_i;
    idx      = AW'(bank) * AW'(BANK_BYTES) + AW'(off);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + OW'(1);
      if (clr_cnt_q == OW'(BANK_BYTES - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      ram_mem[AW'(clr_cnt_q)] <= '0;
    end else if (req_i.ram_wr) begin
      ram_mem[idx] <= wdata_i;
    end
    if (req_i.ram_rd) begin
      ram_rd_q <= ram_mem[idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rom_wr) begin
      rom_mem[idx] <= wdata_i;
    end
    if (req_i.rom_rd) begin
      rom_rd_q <= rom_mem[idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ram_rd || req_i.rom_rd) begin
      rd_ram_q <= req_i.ram_rd;
    end
  end

  assign rdata_o    = rd_ram_q ? ram_rd_q : rom_rd_q;
  assign clearing_o = clr_q;

endmodule
